// ----- rtl/tsi_pkg.sv -----
package tsi_pkg;

    localparam int CH_W     = 8;
    localparam int VALUE_W  = 64;
    localparam int RADIX_W  = 6;
    localparam int COUNT_W  = 16;
    localparam int STATUS_W = 2;
    // six radix bits, so the product grows by six bits over the value
    localparam int PROD_W   = VALUE_W + RADIX_W;
    localparam int STEP_W   = 3;

    localparam logic [STEP_W-1:0] MUL_STEPS = STEP_W'(RADIX_W);

    localparam logic [CH_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CH_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CH_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CH_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CH_W-1:0] CH_UPPER_X = 8'h58;
    localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CH_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CH_W-1:0] CH_LOWER_X = 8'h78;

    localparam logic [RADIX_W-1:0] RADIX_DETECT = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_ONE    = 6'd1;
    localparam logic [RADIX_W-1:0] RADIX_OCT    = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC    = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX    = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_MAX    = 6'd36;
    localparam logic [RADIX_W-1:0] NO_DIGIT     = 6'h3F;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_NONE  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        PH_SPACE  = 3'd0,
        PH_FIRST  = 3'd1,
        PH_ZERO   = 3'd2,
        PH_ZEROX  = 3'd3,
        PH_DIGITS = 3'd4,
        PH_DONE   = 3'd5,
        PH_BAD    = 3'd6
    } phase_t;

    typedef enum logic {
        SQ_IDLE = 1'b0,
        SQ_MUL  = 1'b1
    } seq_t;

    function automatic logic [RADIX_W-1:0] digit_of(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] t;
        begin
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                t = c - CH_ZERO;
            end
            else if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
            begin
                t = c - CH_LOWER_A + 8'd10;
            end
            else if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            begin
                t = c - CH_UPPER_A + 8'd10;
            end
            else
            begin
                t = {2'b00, NO_DIGIT};
            end
            return t[RADIX_W-1:0];
        end
    endfunction

endpackage

// ----- rtl/text_to_signed_integer.sv -----
// Streaming text to signed 64-bit integer converter with strtol behaviour.
// Input channel: one character per transaction on ch (in_valid / in_stall);
// a zero byte ends the string and produces exactly one result transaction
// on value, status and consumed (out_valid / out_stall).
// Configuration: cfg_wr_en with cfg_wr_data writes the radix register
// (0 detects the base from the text, 2 to 36 valid); it is sampled at the
// first non-whitespace character of each string.
// Timing: a digit that is accumulated goes through its accept, six
// shift-add steps of the shared radix multiplier and one saturation
// compare. Every other character, including the terminating zero byte,
// uses no multiplier steps. The result appears in the output register
// the cycle after the zero byte is accepted.
// Stall: the result is held while out_stall is high; a new character is
// refused (in_stall high) while the multiplier runs or while a result is
// held under stall.
// Reset: clears the string state, sets the radix to 10 and drops any
// pending result.
module text_to_signed_integer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [tsi_pkg::RADIX_W-1:0]         cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [tsi_pkg::CH_W-1:0]            ch,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [tsi_pkg::VALUE_W-1:0]  value,
    output logic [tsi_pkg::STATUS_W-1:0]        status,
    output logic [tsi_pkg::COUNT_W-1:0]         consumed
);

    tsi_pkg::seq_t                 seq_reg, seq_next;
    tsi_pkg::phase_t               phase_reg, phase_next;
    logic [tsi_pkg::VALUE_W-1:0]   acc_reg, acc_next;
    logic                          neg_reg, neg_next;
    logic [tsi_pkg::RADIX_W-1:0]   ar_reg, ar_next;
    logic                          sat_reg, sat_next;
    logic                          seen_reg, seen_next;
    logic [tsi_pkg::COUNT_W-1:0]   idx_reg, idx_next;
    logic [tsi_pkg::COUNT_W-1:0]   end_reg, end_next;
    logic [tsi_pkg::RADIX_W-1:0]   radix_reg, radix_next;
    logic                          out_valid_reg, out_valid_next;
    logic [tsi_pkg::VALUE_W-1:0]   value_reg, value_next;
    tsi_pkg::status_t              status_reg, status_next;
    logic [tsi_pkg::COUNT_W-1:0]   consumed_reg, consumed_next;

    logic                          accept;
    logic                          load_out;
    logic [tsi_pkg::RADIX_W-1:0]   digit;
    logic                          is_ws;
    logic [tsi_pkg::COUNT_W-1:0]   idx_inc;
    logic [tsi_pkg::VALUE_W-1:0]   limit;
    logic                          mul_start;
    logic [tsi_pkg::RADIX_W-1:0]   mul_radix;
    logic [tsi_pkg::RADIX_W-1:0]   mul_digit;
    logic                          mul_done;
    logic [tsi_pkg::PROD_W-1:0]    mul_prod;
    logic [tsi_pkg::RADIX_W-1:0]   ar_t;
    logic                          first_path;
    logic                          dig_path;
    logic                          take_zero;
    logic                          take_d;

    tsi_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .mcand  (acc_reg),
        .mult   (mul_radix),
        .addend (mul_digit),
        .done   (mul_done),
        .prod   (mul_prod)
    );

    assign accept   = in_valid && !in_stall;
    assign in_stall = (seq_reg != tsi_pkg::SQ_IDLE) || (out_valid_reg && out_stall);
    assign digit    = tsi_pkg::digit_of(ch);
    assign is_ws    = (ch >= tsi_pkg::CH_TAB && ch <= tsi_pkg::CH_CR) ||
                      (ch == tsi_pkg::CH_SPACE);
    assign idx_inc  = (idx_reg == '1) ? idx_reg : idx_reg + 1'b1;
    assign limit    = {neg_reg, {(tsi_pkg::VALUE_W-1){~neg_reg}}};

    always_comb
    begin
        seq_next       = seq_reg;
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        ar_next        = ar_reg;
        sat_next       = sat_reg;
        seen_next      = seen_reg;
        idx_next       = idx_reg;
        end_next       = end_reg;
        radix_next     = cfg_wr_en ? cfg_wr_data : radix_reg;
        load_out       = 1'b0;
        mul_start      = 1'b0;
        mul_radix      = ar_reg;
        mul_digit      = digit;
        ar_t           = ar_reg;
        first_path     = 1'b0;
        dig_path       = 1'b0;
        take_zero      = 1'b0;
        take_d         = 1'b0;

        unique case (seq_reg)
            tsi_pkg::SQ_IDLE:
            begin
                if (accept && ch == tsi_pkg::CH_NUL)
                begin
                    load_out   = 1'b1;
                    phase_next = tsi_pkg::PH_SPACE;
                    acc_next   = '0;
                    neg_next   = 1'b0;
                    ar_next    = '0;
                    sat_next   = 1'b0;
                    seen_next  = 1'b0;
                    idx_next   = '0;
                    end_next   = '0;
                end
                else if (accept)
                begin
                    unique case (phase_reg)
                        tsi_pkg::PH_SPACE:
                        begin
                            if (!is_ws)
                            begin
                                ar_t = radix_reg;
                                if (radix_reg == tsi_pkg::RADIX_ONE ||
                                    radix_reg > tsi_pkg::RADIX_MAX)
                                begin
                                    phase_next = tsi_pkg::PH_BAD;
                                end
                                else if (ch == tsi_pkg::CH_PLUS || ch == tsi_pkg::CH_MINUS)
                                begin
                                    neg_next   = (ch == tsi_pkg::CH_MINUS);
                                    phase_next = tsi_pkg::PH_FIRST;
                                end
                                else
                                begin
                                    first_path = 1'b1;
                                end
                            end
                        end
                        tsi_pkg::PH_FIRST:
                        begin
                            first_path = 1'b1;
                        end
                        tsi_pkg::PH_ZERO:
                        begin
                            if (ch == tsi_pkg::CH_LOWER_X || ch == tsi_pkg::CH_UPPER_X)
                            begin
                                phase_next = tsi_pkg::PH_ZEROX;
                            end
                            else
                            begin
                                if (ar_reg == tsi_pkg::RADIX_DETECT)
                                begin
                                    ar_t = tsi_pkg::RADIX_OCT;
                                end
                                phase_next = tsi_pkg::PH_DIGITS;
                                dig_path   = 1'b1;
                            end
                        end
                        tsi_pkg::PH_ZEROX:
                        begin
                            if (digit < tsi_pkg::RADIX_HEX)
                            begin
                                ar_t       = tsi_pkg::RADIX_HEX;
                                phase_next = tsi_pkg::PH_DIGITS;
                                take_d     = 1'b1;
                            end
                            else
                            begin
                                phase_next = tsi_pkg::PH_DONE;
                            end
                        end
                        tsi_pkg::PH_DIGITS:
                        begin
                            dig_path = 1'b1;
                        end
                        tsi_pkg::PH_DONE, tsi_pkg::PH_BAD:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase

                    if (first_path)
                    begin
                        // a leading zero counts as a digit and may open a hex prefix
                        if ((ar_t == tsi_pkg::RADIX_DETECT || ar_t == tsi_pkg::RADIX_HEX) &&
                            ch == tsi_pkg::CH_ZERO)
                        begin
                            take_zero  = 1'b1;
                            phase_next = tsi_pkg::PH_ZERO;
                        end
                        else
                        begin
                            if (ar_t == tsi_pkg::RADIX_DETECT)
                            begin
                                ar_t = tsi_pkg::RADIX_DEC;
                            end
                            phase_next = tsi_pkg::PH_DIGITS;
                            dig_path   = 1'b1;
                        end
                    end

                    if (dig_path)
                    begin
                        if (digit < ar_t)
                        begin
                            take_d = 1'b1;
                        end
                        else
                        begin
                            phase_next = tsi_pkg::PH_DONE;
                        end
                    end

                    ar_next  = ar_t;
                    idx_next = idx_inc;
                    if (take_zero || take_d)
                    begin
                        seen_next = 1'b1;
                        end_next  = idx_inc;
                    end
                    if (take_d && !sat_reg)
                    begin
                        mul_start = 1'b1;
                        mul_radix = ar_t;
                        seq_next  = tsi_pkg::SQ_MUL;
                    end
                end
            end
            tsi_pkg::SQ_MUL:
            begin
                if (mul_done)
                begin
                    // saturate once the product passes the signed limit
                    if (mul_prod > {{tsi_pkg::RADIX_W{1'b0}}, limit})
                    begin
                        sat_next = 1'b1;
                        acc_next = limit;
                    end
                    else
                    begin
                        acc_next = mul_prod[tsi_pkg::VALUE_W-1:0];
                    end
                    seq_next = tsi_pkg::SQ_IDLE;
                end
            end
            default:
            begin
                seq_next = tsi_pkg::SQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        value_next     = value_reg;
        status_next    = status_reg;
        consumed_next  = consumed_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            if (phase_reg == tsi_pkg::PH_BAD || !seen_reg)
            begin
                value_next    = '0;
                status_next   = tsi_pkg::ST_NONE;
                consumed_next = '0;
            end
            else
            begin
                value_next    = neg_reg ? ('0 - acc_reg) : acc_reg;
                status_next   = sat_reg ? tsi_pkg::ST_RANGE : tsi_pkg::ST_OK;
                consumed_next = end_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= tsi_pkg::SQ_IDLE;
            phase_reg     <= tsi_pkg::PH_SPACE;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            ar_reg        <= '0;
            sat_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            idx_reg       <= '0;
            end_reg       <= '0;
            radix_reg     <= tsi_pkg::RADIX_DEC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            ar_reg        <= ar_next;
            sat_reg       <= sat_next;
            seen_reg      <= seen_next;
            idx_reg       <= idx_next;
            end_reg       <= end_next;
            radix_reg     <= radix_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        status_reg   <= status_next;
        consumed_reg <= consumed_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;
    assign consumed  = consumed_reg;

`ifndef SYNTHESIS
    a_mul_latency: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> ##7 mul_done)
        else $error("multiplier did not finish in six steps");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        sat_reg |-> (acc_reg == limit))
        else $error("saturated accumulator is not at the signed limit");

    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == tsi_pkg::ST_NONE) |->
            (value_reg == '0 && consumed_reg == '0))
        else $error("failed conversion carries a value or count");
`endif

endmodule

// ----- rtl/tsi_mul.sv -----
module tsi_mul (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [tsi_pkg::VALUE_W-1:0]      mcand,
    input  logic [tsi_pkg::RADIX_W-1:0]      mult,
    input  logic [tsi_pkg::RADIX_W-1:0]      addend,
    output logic                             done,
    output logic [tsi_pkg::PROD_W-1:0]       prod
);

    logic [tsi_pkg::STEP_W-1:0]  cnt_reg, cnt_next;
    logic                        done_reg, done_next;
    logic [tsi_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic [tsi_pkg::PROD_W-1:0]  mcand_reg, mcand_next;
    logic [tsi_pkg::RADIX_W-1:0] mult_reg, mult_next;

    always_comb
    begin
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        prod_next  = prod_reg;
        mcand_next = mcand_reg;
        mult_next  = mult_reg;
        if (start)
        begin
            cnt_next   = tsi_pkg::MUL_STEPS;
            prod_next  = {{(tsi_pkg::PROD_W-tsi_pkg::RADIX_W){1'b0}}, addend};
            mcand_next = {{tsi_pkg::RADIX_W{1'b0}}, mcand};
            mult_next  = mult;
        end
        else if (cnt_reg != '0)
        begin
            // add one shifted partial product per radix bit
            if (mult_reg[0])
            begin
                prod_next = prod_reg + mcand_reg;
            end
            mcand_next = {mcand_reg[tsi_pkg::PROD_W-2:0], 1'b0};
            mult_next  = {1'b0, mult_reg[tsi_pkg::RADIX_W-1:1]};
            cnt_next   = cnt_reg - 1'b1;
            done_next  = (cnt_reg == tsi_pkg::STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        mcand_reg <= mcand_next;
        mult_reg  <= mult_next;
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import tsi_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned NOT_A_DIGIT = 99;
    localparam int unsigned COUNT_CAP   = 65535;
    localparam int unsigned RANDOM_CHARS = 975;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        status_t                   status;
        logic [COUNT_W-1:0]        consumed;
    } conv_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [RADIX_W-1:0]         cfg_wr_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [CH_W-1:0]            ch = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0]        status;
    logic [COUNT_W-1:0]         consumed;

    logic [CH_W-1:0]  text_bytes[$];
    conv_result_t     predicted_results[$];
    int unsigned      queued_chars = 0;
    int unsigned      mismatches = 0;
    int unsigned      cycle_count = 0;
    int unsigned      in_gap = 0;
    int unsigned      out_hold = 0;
    bit               in_calm = 1'b0;
    bit               out_calm = 1'b0;

    logic [RADIX_W-1:0] radix_setting = RADIX_DEC;
    phase_t             conv_phase = PH_SPACE;
    logic [VALUE_W-1:0] conv_mag = '0;
    bit                 conv_neg = 1'b0;
    logic [RADIX_W-1:0] conv_base = '0;
    bit                 conv_sat = 1'b0;
    bit                 conv_any_digit = 1'b0;
    int unsigned        conv_pos = 0;
    int unsigned        conv_end = 0;

    text_to_signed_integer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .ch          (ch),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .value       (value),
        .status      (status),
        .consumed    (consumed)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int unsigned char_digit(input logic [CH_W-1:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            return c - CH_ZERO;
        end
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
        begin
            return c - CH_LOWER_A + 10;
        end
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            return c - CH_UPPER_A + 10;
        end
        return NOT_A_DIGIT;
    endfunction

    function automatic int unsigned bump_pos();
        return (conv_pos < COUNT_CAP) ? conv_pos + 1 : COUNT_CAP;
    endfunction

    function automatic void clear_string();
        conv_phase = PH_SPACE;
        conv_mag = '0;
        conv_neg = 1'b0;
        conv_base = '0;
        conv_sat = 1'b0;
        conv_any_digit = 1'b0;
        conv_pos = 0;
        conv_end = 0;
    endfunction

    function automatic void take_digit(input int unsigned d, input int unsigned b);
        logic [VALUE_W-1:0] lim;
        logic [VALUE_W-1:0] b64;
        lim = conv_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        b64 = 64'(b);
        if (!conv_sat)
        begin
            if (conv_mag > (lim - 64'(d)) / b64)
            begin
                conv_sat = 1'b1;
                conv_mag = lim;
            end
            else
            begin
                conv_mag = conv_mag * b64 + 64'(d);
            end
        end
        conv_any_digit = 1'b1;
        conv_end = bump_pos();
    endfunction

    function automatic void digit_step(input logic [CH_W-1:0] c);
        int unsigned d;
        d = char_digit(c);
        if (d < conv_base)
        begin
            take_digit(d, conv_base);
        end
        else
        begin
            conv_phase = PH_DONE;
        end
    endfunction

    function automatic void lead_char(input logic [CH_W-1:0] c);
        if ((conv_base == RADIX_DETECT || conv_base == RADIX_HEX) && c == CH_ZERO)
        begin
            take_digit(0, RADIX_OCT);
            conv_phase = PH_ZERO;
        end
        else
        begin
            if (conv_base == RADIX_DETECT)
            begin
                conv_base = RADIX_DEC;
            end
            conv_phase = PH_DIGITS;
            digit_step(c);
        end
    endfunction

    function automatic void convert_char(input logic [CH_W-1:0] c);
        conv_result_t r;
        if (c == CH_NUL)
        begin
            if (conv_phase == PH_BAD || !conv_any_digit)
            begin
                r.value = '0;
                r.status = ST_NONE;
                r.consumed = '0;
            end
            else
            begin
                r.value = conv_neg ? -conv_mag : conv_mag;
                r.status = conv_sat ? ST_RANGE : ST_OK;
                r.consumed = conv_end[COUNT_W-1:0];
            end
            predicted_results.push_back(r);
            clear_string();
        end
        else
        begin
            case (conv_phase)
                PH_SPACE:
                begin
                    if (!((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE))
                    begin
                        conv_base = radix_setting;
                        if (radix_setting == RADIX_ONE || radix_setting > RADIX_MAX)
                        begin
                            conv_phase = PH_BAD;
                        end
                        else if (c == CH_PLUS || c == CH_MINUS)
                        begin
                            conv_neg = (c == CH_MINUS);
                            conv_phase = PH_FIRST;
                        end
                        else
                        begin
                            lead_char(c);
                        end
                    end
                end
                PH_FIRST:
                begin
                    lead_char(c);
                end
                PH_ZERO:
                begin
                    if (c == CH_LOWER_X || c == CH_UPPER_X)
                    begin
                        conv_phase = PH_ZEROX;
                    end
                    else
                    begin
                        if (conv_base == RADIX_DETECT)
                        begin
                            conv_base = RADIX_OCT;
                        end
                        conv_phase = PH_DIGITS;
                        digit_step(c);
                    end
                end
                PH_ZEROX:
                begin
                    if (char_digit(c) < RADIX_HEX)
                    begin
                        conv_base = RADIX_HEX;
                        conv_phase = PH_DIGITS;
                        take_digit(char_digit(c), RADIX_HEX);
                    end
                    else
                    begin
                        conv_phase = PH_DONE;
                    end
                end
                PH_DIGITS:
                begin
                    digit_step(c);
                end
                default:
                begin
                end
            endcase
            conv_pos = bump_pos();
        end
    endfunction

    function automatic int unsigned pick_pause();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [CH_W-1:0] digit_char(input int unsigned d);
        if (d < 10)
        begin
            return CH_ZERO + 8'(d);
        end
        return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + 8'(d - 10);
    endfunction

    task automatic put_char(input logic [CH_W-1:0] c);
        text_bytes.push_back(c);
        queued_chars++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            put_char(s[i]);
        end
        put_char(CH_NUL);
    endtask

    task automatic put_random_string();
        int unsigned kind;
        int unsigned n;
        int unsigned b;
        int unsigned d;
        kind = $urandom_range(0, 99);
        if (kind < 75)
        begin
            n = $urandom_range(0, 3);
            repeat (n)
            begin
                d = $urandom_range(0, 6);
                put_char((d == 6) ? CH_SPACE : CH_TAB + 8'(d));
            end
            d = $urandom_range(0, 3);
            if (d == 0)
            begin
                put_char(CH_PLUS);
            end
            else if (d == 1)
            begin
                put_char(CH_MINUS);
            end
            b = radix_setting;
            if (b == RADIX_DETECT)
            begin
                d = $urandom_range(0, 2);
                if (d == 0)
                begin
                    put_char(CH_ZERO);
                    put_char($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
                    b = RADIX_HEX;
                end
                else if (d == 1)
                begin
                    put_char(CH_ZERO);
                    b = RADIX_OCT;
                end
                else
                begin
                    put_char(digit_char($urandom_range(1, 9)));
                    b = RADIX_DEC;
                end
            end
            else if (b == RADIX_HEX && $urandom_range(0, 1) == 1)
            begin
                put_char(CH_ZERO);
                put_char($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
            end
            else if (b == RADIX_ONE || b > RADIX_MAX)
            begin
                b = RADIX_DEC;
            end
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 70) : $urandom_range(1, 6);
            repeat (n)
            begin
                put_char(digit_char($urandom_range(0, b - 1)));
            end
            if ($urandom_range(0, 9) < 3)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    put_char(8'($urandom_range(1, 255)));
                end
            end
        end
        else if (kind < 88)
        begin
            repeat ($urandom_range(0, 10))
            begin
                put_char(8'($urandom_range(1, 255)));
            end
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    put_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                end
                1:
                begin
                    put_char(CH_ZERO);
                    put_char(CH_LOWER_X);
                    put_char(CH_LOWER_A + 8'($urandom_range(6, 25)));
                    put_char(digit_char($urandom_range(0, 9)));
                end
                2:
                begin
                    put_char(CH_MINUS);
                    put_char(CH_PLUS);
                    put_char(digit_char($urandom_range(0, 9)));
                end
                default:
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        put_char(CH_SPACE);
                    end
                end
            endcase
        end
        put_char(CH_NUL);
    endtask

    task automatic drain();
        @(negedge clk);
        while (text_bytes.size() != 0 || in_valid || predicted_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (16) @(negedge clk);
    endtask

    task automatic set_radix(input logic [RADIX_W-1:0] r);
        drain();
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= r;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        radix_setting = r;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                convert_char(ch);
                if ($urandom_range(0, 99) == 0)
                begin
                    in_calm = !in_calm;
                end
                in_gap = in_calm ? 0 : pick_pause();
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap != 0 || text_bytes.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (in_gap != 0)
                    begin
                        in_gap--;
                    end
                end
                else
                begin
                    in_valid <= 1'b1;
                    ch <= text_bytes.pop_front();
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        conv_result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected result: value %0d status %0d consumed %0d",
                                 value, status, consumed);
                    end
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (want.value !== value || want.status !== status
                        || want.consumed !== consumed)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: value exp %0d got %0d, status exp %0d got %0d",
                                     want.value, value, want.status, status);
                            $display("          consumed exp %0d got %0d",
                                     want.consumed, consumed);
                        end
                    end
                end
            end
            if ($urandom_range(0, 199) == 0)
            begin
                out_calm = !out_calm;
            end
            if (out_hold != 0)
            begin
                out_stall <= 1'b1;
                out_hold--;
            end
            else
            begin
                out_stall <= 1'b0;
                out_hold = out_calm ? 0 : pick_pause();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned start_count;
        int unsigned mark;
        int unsigned pick;
        logic [RADIX_W-1:0] r;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // decimal after reset
        send_text("");
        send_text("0");
        send_text("-0");
        send_text("+123");
        for (int c = CH_TAB; c <= CH_CR; c++)
        begin
            put_char(8'(c));
        end
        put_char(CH_SPACE);
        send_text("-42");
        send_text("12abc");
        send_text("abc");
        send_text("+");
        send_text("0x1f");
        send_text("9223372036854775807");
        send_text("-9223372036854775808");
        send_text("9223372036854775808");
        send_text("-9223372036854775809");
        send_text("99999999999999999999999");
        put_char(8'hFF);
        put_char(8'h80);
        put_char(CH_NUL);

        set_radix(RADIX_DETECT);
        send_text("0x1F");
        send_text("0xg");
        send_text("017");
        send_text("08");
        send_text("123");
        send_text("-0X7fffffffffffffff");
        send_text("0");

        set_radix(RADIX_HEX);
        send_text("0xff");
        send_text("FF");
        send_text("0x");
        send_text("-8000000000000000");

        set_radix(6'd2);
        send_text("1011");
        put_char(CH_MINUS);
        put_char(CH_ZERO + 8'd1);
        repeat (63) put_char(CH_ZERO);
        put_char(CH_NUL);
        repeat (64) put_char(CH_ZERO + 8'd1);
        put_char(CH_NUL);

        set_radix(RADIX_MAX);
        send_text("zZ");
        send_text("-Zz9");

        set_radix(RADIX_OCT);
        send_text("777");
        send_text("8");

        set_radix(RADIX_ONE);
        send_text("5");
        set_radix(6'd37);
        send_text("5");
        set_radix(6'd63);
        send_text(" -7");

        start_count = queued_chars;
        while (queued_chars - start_count < RANDOM_CHARS)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: r = RADIX_DETECT;
                1: r = RADIX_HEX;
                2: r = RADIX_DEC;
                3: r = 6'd2;
                4: r = RADIX_MAX;
                5: r = RADIX_OCT;
                6: r = $urandom_range(0, 1) ? RADIX_ONE : 6'($urandom_range(37, 63));
                default: r = 6'($urandom_range(2, 36));
            endcase
            set_radix(r);
            mark = queued_chars;
            while (queued_chars - mark < 130)
            begin
                put_random_string();
            end
        end

        drain();

        if (mismatches == 0 && predicted_results.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
